/* hdl/sis_pkg.sv */
// ----------------------------------------------------------------------------
// sis_pkg
// shared action codes and the result type of the key compare unit
// ----------------------------------------------------------------------------
package sis_pkg;

    typedef logic [2:0] t_action;

    localparam t_action ACT_ADD      = 3'd0;
    localparam t_action ACT_REMOVE   = 3'd1;
    localparam t_action ACT_CONTAINS = 3'd2;
    localparam t_action ACT_CLEAR    = 3'd3;
    localparam t_action ACT_READ     = 3'd4;

    // outcome of comparing a stored key against the request key
    typedef struct packed {
        logic lt;   // stored key below request key
        logic eq;   // stored key equal to request key
    } t_cmp_res;

endpackage

/* hdl/sis_cmp.sv */
// ----------------------------------------------------------------------------
// sis_cmp
// shared signed key comparator used by the search sequencer
// ----------------------------------------------------------------------------
module sis_cmp
    import sis_pkg::*;
#(
    parameter int KEY_WIDTH = 32
) (
    input  logic signed [KEY_WIDTH-1:0] i_a,
    input  logic signed [KEY_WIDTH-1:0] i_b,
    output t_cmp_res                    o_res
);

    assign o_res.lt = (i_a < i_b);
    assign o_res.eq = (i_a == i_b);

endmodule

/* hdl/sis_store.sv */
// ----------------------------------------------------------------------------
// sis_store
// key store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module sis_store #(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [$clog2(CAPACITY)-1:0]   i_waddr,
    input  logic signed [KEY_WIDTH-1:0]   i_wdata,
    input  logic [$clog2(CAPACITY)-1:0]   i_raddr,
    output logic signed [KEY_WIDTH-1:0]   o_rdata
);

    logic signed [KEY_WIDTH-1:0] r_mem [CAPACITY];
    logic signed [KEY_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/sorted_integer_set.sv */
// ----------------------------------------------------------------------------
// sorted_integer_set
// set of distinct signed keys kept in ascending order in a one-read, one-write store
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with o_strobe high, and it cannot be held off.
// Clear, unused action codes and a read past the end answer straight from
// idle; a read at a valid position first waits in S_READ for the store data.
// Add, remove and contains first run a binary search over the held keys:
// each halving step reads the store, then compares (S_LOOK, S_CMP), and a
// check read then compares the key at the insert point if it lies below the
// count. An add then moves every key from the insert point up by one, and a
// remove moves every key above the hole down by one, each moved key read,
// then written back one place over. o_count shows the count after the
// action once o_strobe is high; an add to a full store is dropped with
// o_status high, unless the key is already present.
// ----------------------------------------------------------------------------
module sorted_integer_set
    import sis_pkg::*;
#(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [2:0]                          i_action,
    input  logic signed [KEY_WIDTH-1:0]         i_key,
    input  logic [$clog2(CAPACITY)-1:0]         i_position,
    output logic                                o_strobe,
    output logic                                o_found,
    output logic                                o_status,
    output logic [$clog2(CAPACITY+1)-1:0]       o_count,
    output logic signed [KEY_WIDTH-1:0]         o_element,
    output logic                                o_more
);

    localparam int AW = $clog2(CAPACITY);       // store address bits
    localparam int CW = $clog2(CAPACITY + 1);   // count and index bits

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_READ   = 4'd1;   // read_at data returns
    localparam logic [3:0] S_LOOK   = 4'd2;   // search step: pick probe
    localparam logic [3:0] S_CMP    = 4'd3;   // search step: compare probe
    localparam logic [3:0] S_CHECK  = 4'd4;   // compare key at insert point
    localparam logic [3:0] S_INS_RD = 4'd5;   // open gap: read lower key
    localparam logic [3:0] S_INS_WR = 4'd6;   // open gap: write it one up
    localparam logic [3:0] S_DEL_RD = 4'd7;   // close gap: read upper key
    localparam logic [3:0] S_DEL_WR = 4'd8;   // close gap: write it one down

    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE        = CW'(1);

    // sequencer and request registers
    logic [3:0]                  r_state,   n_state;
    logic [CW-1:0]               r_lo,      n_lo;      // search window low, insert point
    logic [CW-1:0]               r_hi,      n_hi;      // search window high
    logic [CW-1:0]               r_mid,     n_mid;     // current probe
    logic [CW-1:0]               r_idx,     n_idx;     // shift pointer
    logic [CW-1:0]               r_used,    n_used;    // element count
    logic signed [KEY_WIDTH-1:0] r_key,     n_key;
    t_action                     r_action,  n_action;

    // result registers
    logic                        r_strobe,  n_strobe;
    logic                        r_found,   n_found;
    logic                        r_status,  n_status;
    logic signed [KEY_WIDTH-1:0] r_element, n_element;
    logic                        r_more,    n_more;

    // store port
    logic                        mem_we;
    logic [CW-1:0]               mem_waddr;
    logic signed [KEY_WIDTH-1:0] mem_wdata;
    logic [CW-1:0]               mem_raddr;
    logic signed [KEY_WIDTH-1:0] mem_rdata;

    // shared compare unit: stored key against request key
    t_cmp_res                    cmp_res;

    logic [CW:0]                 mid_sum;
    logic [CW-1:0]               mid;
    logic [CW-1:0]               pos_ext;
    logic                        take_branch;
    logic                        br_present;

    sis_store #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr[AW-1:0]),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    sis_cmp #(
        .KEY_WIDTH (KEY_WIDTH)
    ) u_cmp (
        .i_a   (mem_rdata),
        .i_b   (r_key),
        .o_res (cmp_res)
    );

    // probe sits in the middle of the open window [lo, hi)
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[CW:1];
    assign pos_ext = CW'(i_position);

    always_comb begin
        n_state     = r_state;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_idx       = r_idx;
        n_used      = r_used;
        n_key       = r_key;
        n_action    = r_action;
        n_strobe    = 1'b0;
        n_found     = r_found;
        n_status    = r_status;
        n_element   = r_element;
        n_more      = r_more;
        mem_we      = 1'b0;
        mem_waddr   = r_idx;
        mem_wdata   = mem_rdata;
        mem_raddr   = r_lo;
        take_branch = 1'b0;
        br_present  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_key     = i_key;
                    n_action  = i_action;
                    n_found   = 1'b0;
                    n_status  = 1'b0;
                    n_element = '0;
                    n_more    = 1'b0;
                    n_lo      = '0;
                    n_hi      = r_used;
                    case (i_action)
                        ACT_ADD, ACT_REMOVE, ACT_CONTAINS: begin
                            n_state = S_LOOK;
                        end
                        ACT_CLEAR: begin
                            n_used   = '0;
                            n_strobe = 1'b1;
                        end
                        ACT_READ: begin
                            if (pos_ext < r_used) begin
                                mem_raddr = pos_ext;
                                n_state   = S_READ;
                            end else begin
                                n_strobe = 1'b1;
                            end
                        end
                        default: begin
                            // unused codes: count only
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_element = mem_rdata;
                n_more    = 1'b1;
                n_strobe  = 1'b1;
                n_state   = S_IDLE;
            end
            S_LOOK: begin
                if (r_lo == r_hi) begin
                    // window closed: r_lo is the first key not below the request
                    if (r_lo < r_used) begin
                        mem_raddr = r_lo;
                        n_state   = S_CHECK;
                    end else begin
                        take_branch = 1'b1;
                        br_present  = 1'b0;
                    end
                end else begin
                    mem_raddr = mid;
                    n_mid     = mid;
                    n_state   = S_CMP;
                end
            end
            S_CMP: begin
                if (cmp_res.lt) begin
                    n_lo = r_mid + ONE;
                end else begin
                    n_hi = r_mid;
                end
                n_state = S_LOOK;
            end
            S_CHECK: begin
                take_branch = 1'b1;
                br_present  = cmp_res.eq;
            end
            S_INS_RD: begin
                if (r_idx == r_lo) begin
                    // gap is open at the insert point
                    mem_we    = 1'b1;
                    mem_waddr = r_lo;
                    mem_wdata = r_key;
                    n_used    = r_used + ONE;
                    n_strobe  = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    mem_raddr = r_idx - ONE;
                    n_state   = S_INS_WR;
                end
            end
            S_INS_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = mem_rdata;
                n_idx     = r_idx - ONE;
                n_state   = S_INS_RD;
            end
            S_DEL_RD: begin
                if (({1'b0, r_idx} + {1'b0, ONE}) >= {1'b0, r_used}) begin
                    n_used   = r_used - ONE;
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    mem_raddr = r_idx + ONE;
                    n_state   = S_DEL_WR;
                end
            end
            S_DEL_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = mem_rdata;
                n_idx     = r_idx + ONE;
                n_state   = S_DEL_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // search finished: decide what the action does with the result
        if (take_branch) begin
            n_found = br_present;
            n_state = S_IDLE;
            case (r_action)
                ACT_ADD: begin
                    if (br_present) begin
                        n_strobe = 1'b1;
                    end else if (r_used == FULL_COUNT) begin
                        n_status = 1'b1;
                        n_strobe = 1'b1;
                    end else begin
                        n_idx   = r_used;
                        n_state = S_INS_RD;
                    end
                end
                ACT_REMOVE: begin
                    if (br_present) begin
                        n_idx   = r_lo;
                        n_state = S_DEL_RD;
                    end else begin
                        n_strobe = 1'b1;
                    end
                end
                default: begin
                    n_strobe = 1'b1;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_strobe <= n_strobe;
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_idx     <= n_idx;
        r_key     <= n_key;
        r_action  <= n_action;
        r_found   <= n_found;
        r_status  <= n_status;
        r_element <= n_element;
        r_more    <= n_more;
    end

    assign busy      = (r_state != S_IDLE);
    assign o_strobe  = r_strobe;
    assign o_found   = r_found;
    assign o_status  = r_status;
    assign o_count   = r_used;
    assign o_element = r_element;
    assign o_more    = r_more;

endmodule

/* hdl/sis_check.sv */
// ----------------------------------------------------------------------------
// sis_check
// port-level checks on the sorted set, bound to the top level
// ----------------------------------------------------------------------------
module sis_check #(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_strobe,
    input logic                          o_found,
    input logic                          o_status,
    input logic [$clog2(CAPACITY+1)-1:0] o_count,
    input logic signed [KEY_WIDTH-1:0]   o_element,
    input logic                          o_more
);

    // a request either keeps the block busy or answers at once
    a_req_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_strobe))
        else $error("request neither started work nor answered");

    // when busy drops, the result comes out in the same cycle
    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("work ended without a result");

    // no result without a request in flight
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy || start))
        else $error("result without a request");

    // a refused add only happens on a full store, and reports nothing else
    a_full_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status) |->
            (o_count == ($clog2(CAPACITY+1))'(CAPACITY) && !o_found && !o_more
             && o_element == '0))
        else $error("full status on a store that is not full");

    // count never exceeds the store size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_count <= ($clog2(CAPACITY+1))'(CAPACITY)))
        else $error("count beyond capacity");

endmodule

bind sorted_integer_set sis_check #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
) u_sis_check (.*);
